### hw/rtl/gdsh_pkg.sv
package gdsh_pkg;

	localparam int MAX_CELLS_DEF = 64;
	localparam int NUM_BINS_DEF  = 8192;
	localparam int TABLES        = 4;
	localparam int KEY_W         = 20;
	localparam int SUM_W         = 32;
	localparam int CNT_W         = 32;
	localparam int SHIFT_W       = 5;
	localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST = 5'd11;

	localparam logic [1:0] MODE_DEPOSIT = 2'd0;
	localparam logic [1:0] MODE_EOE     = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;
	localparam logic [1:0] MODE_CLEAR   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DROP = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [19:0] cell_id;
		logic [1:0]  volume_type;
		logic [23:0] energy_ev;
		logic [1:0]  hist_select;
		logic [13:0] bin_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} rsp_t;

	// Token travelling along one table's chain of cells.
	typedef struct packed {
		logic              vld;    // deposit in flight
		logic              hit;    // already absorbed by a cell
		logic              sat;
		logic [KEY_W-1:0]  key;
		logic [23:0]       energy;
	} tok_t;

	// Control broadcast to every cell of one table.
	typedef struct packed {
		logic flush;   // drop all entries; the top holds it low
		logic shift;   // shift sums one cell toward the head
	} cell_ctl_t;

endpackage

### hw/rtl/grouped_deposit_sum_histogram_top.sv
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             req   (gdsh_pkg::req_t)
// result    out        done strobe, one cycle    rsp   (gdsh_pkg::rsp_t)
// config    in         cfg_valid & cfg_ready     cfg_data (bin_shift, 5 bits)
//
// Deposit: the token walks the chain of cells; its status is taken at the far end.
// End of event: sums drained one cell a cycle,
// each a read-modify-write of its histogram RAM bin, or an overflow count.
// Read and clear go through their own states; clear zeroes one bin per cycle.
// After reset a clearing pass zeroes the histograms;
// busy is high meanwhile. The receiver cannot stall: done lasts one cycle.
module grouped_deposit_sum_histogram_top #(
	parameter int MAX_CELLS = gdsh_pkg::MAX_CELLS_DEF,
	parameter int NUM_BINS  = gdsh_pkg::NUM_BINS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  gdsh_pkg::req_t                req,
	output logic                          done,
	output gdsh_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gdsh_pkg::SHIFT_W-1:0]  cfg_data
);
	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int CNT_W  = $clog2(2*MAX_CELLS+4);
	localparam int TAB    = gdsh_pkg::TABLES;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEP   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;

	logic [2:0]                   state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [BIN_W:0]               clr_q;
	logic [gdsh_pkg::SHIFT_W-1:0] shift_q;
	gdsh_pkg::req_t               req_q;
	logic [31:0]                  binned_q;
	logic [31:0]                  ovf_q [TAB];

	gdsh_pkg::cell_ctl_t          ctl;
	gdsh_pkg::tok_t               tin  [TAB];
	gdsh_pkg::tok_t               tout [TAB];
	logic                         hvld [TAB];
	logic [gdsh_pkg::SUM_W-1:0]   hsum [TAB];

	// Drain: stage 1 writes the bin back, stage 2 holds it for forwarding.
	logic                         p_vld_s1 [TAB];
	logic                         p_ovf_s1 [TAB];
	logic [BIN_W-1:0]             p_bin_s1 [TAB];
	logic                         p_vld_s2 [TAB];
	logic [BIN_W-1:0]             p_bin_s2 [TAB];
	logic                         fwd      [TAB];
	logic [31:0]                  rd       [TAB];
	logic [31:0]                  cur      [TAB];
	logic [31:0]                  wval_s2  [TAB];
	logic                         we       [TAB];
	logic [BIN_W-1:0]             waddr    [TAB];
	logic [31:0]                  wdata    [TAB];
	logic [BIN_W-1:0]             raddr    [TAB];

	logic accept;
	logic [31:0] bval [TAB];

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	always_comb begin
		ctl.flush = 1'b0;
		ctl.shift = state_q == S_DRAIN;
	end

	for (genvar t = 0; t < TAB; t++) begin : g_tab
		always_comb begin
			tin[t]        = '0;
			tin[t].key    = req.cell_id;
			tin[t].energy = req.energy_ev;
			if (accept && req.mode == gdsh_pkg::MODE_DEPOSIT) begin
				// table 0 total, 1 nucleus, 2 cytoplasm, 3 membrane
				tin[t].vld = (t == 0) || (req.volume_type != 2'd0 &&
					(3'd4 - {1'b0, req.volume_type}) == 3'(t));
			end
		end

		gdsh_table #(.MAX_CELLS(MAX_CELLS)) u_table (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.tok_in   (tin[t]),
			.tok_out  (tout[t]),
			.head_vld (hvld[t]),
			.head_sum (hsum[t])
		);

		logic [31:0] shifted;
		assign shifted = hsum[t] >> shift_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				p_vld_s1[t] <= 1'b0;
				p_vld_s2[t] <= 1'b0;
			end else begin
				p_vld_s1[t] <= ctl.shift && hvld[t];
				p_vld_s2[t] <= p_vld_s1[t] && !p_ovf_s1[t];
			end
		end

		always_ff @(posedge clk) begin
			p_ovf_s1[t] <= shifted >= 32'(NUM_BINS);
			p_bin_s1[t] <= shifted[BIN_W-1:0];
			p_bin_s2[t] <= p_bin_s1[t];
			wval_s2[t]  <= wdata[t];
		end

		assign fwd[t] = p_vld_s2[t] && p_bin_s2[t] == p_bin_s1[t];
		assign cur[t] = fwd[t] ? wval_s2[t] : rd[t];

		always_comb begin
			we[t]    = 1'b0;
			waddr[t] = p_bin_s1[t];
			wdata[t] = (cur[t] == '1) ? cur[t] : cur[t] + 32'd1;
			raddr[t] = ctl.shift ? shifted[BIN_W-1:0] : req_q.bin_index[BIN_W-1:0];
			if (state_q == S_CLEAR) begin
				we[t]    = 1'b1;
				waddr[t] = clr_q[BIN_W-1:0];
				wdata[t] = '0;
			end else if (p_vld_s1[t] && !p_ovf_s1[t]) begin
				we[t] = 1'b1;
			end
		end

		gdsh_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_ram (
			.clk   (clk),
			.we    (we[t]),
			.waddr (waddr[t]),
			.wdata (wdata[t]),
			.raddr (raddr[t]),
			.rdata (rd[t])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ovf_q[t] <= '0;
			end else if (state_q == S_CLEAR && accept == 1'b0 && req_q.mode ==
				gdsh_pkg::MODE_CLEAR && clr_q == '0) begin
				ovf_q[t] <= '0;
			end else if (p_vld_s1[t] && p_ovf_s1[t] && ovf_q[t] != '1) begin
				ovf_q[t] <= ovf_q[t] + 32'd1;
			end
		end

		assign bval[t] = rd[t];
	end

	// Sequencer: hold a request until its result strobes out.
	logic [1:0] tot_st;
	logic [2:0] bincnt;
	always_comb begin
		tot_st = gdsh_pkg::ST_OK;
		if ((tout[0].vld && !tout[0].hit) || (tout[1].vld && !tout[1].hit) ||
			(tout[2].vld && !tout[2].hit) || (tout[3].vld && !tout[3].hit)) begin
			tot_st = gdsh_pkg::ST_DROP;
		end else if ((tout[0].vld && tout[0].sat) || (tout[1].vld && tout[1].sat) ||
			(tout[2].vld && tout[2].sat) || (tout[3].vld && tout[3].sat)) begin
			tot_st = gdsh_pkg::ST_SAT;
		end
		bincnt = 3'(hvld[0]) + 3'(hvld[1]) + 3'(hvld[2]) + 3'(hvld[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			clr_q    <= '0;
			shift_q  <= gdsh_pkg::BIN_SHIFT_RST;
			done     <= 1'b0;
			rsp      <= '0;
			req_q    <= '0;
			binned_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				shift_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= req;
						cnt_q    <= '0;
						clr_q    <= '0;
						binned_q <= '0;
						unique case (req.mode)
							gdsh_pkg::MODE_DEPOSIT: state_q <= S_DEP;
							gdsh_pkg::MODE_EOE:     state_q <= S_DRAIN;
							gdsh_pkg::MODE_READ:    state_q <= S_READ;
							gdsh_pkg::MODE_CLEAR:   state_q <= S_CLEAR;
							default:                state_q <= S_IDLE;
						endcase
					end
				end
				S_DEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAX_CELLS - 1)) begin
						rsp.status <= tot_st;
						rsp.value  <= '0;
						done       <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_DRAIN: begin
					cnt_q    <= cnt_q + 1'b1;
					binned_q <= binned_q + 32'(bincnt);
					if (cnt_q == CNT_W'(MAX_CELLS + 1)) begin
						rsp.status <= gdsh_pkg::ST_OK;
						rsp.value  <= binned_q + 32'(bincnt);
						done       <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						rsp.status <= gdsh_pkg::ST_OK;
						if ({2'b0, req_q.bin_index} < 16'(NUM_BINS)) begin
							rsp.value <= bval[req_q.hist_select];
						end else if ({2'b0, req_q.bin_index} == 16'(NUM_BINS)) begin
							rsp.value <= ovf_q[req_q.hist_select];
						end else begin
							rsp.value <= '0;
						end
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (BIN_W+1)'(NUM_BINS - 1)) begin
						if (req_q.mode == gdsh_pkg::MODE_CLEAR) begin
							rsp.status <= gdsh_pkg::ST_OK;
							rsp.value  <= '0;
							done       <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result strobe only ever closes a busy request.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without request");
	// No request is taken while the previous one is in flight.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept) else $error("request overlap");
	// Configuration is only written while idle.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> state_q == S_IDLE) else $error("cfg while busy");
endmodule

### hw/rtl/gdsh_ram.sv
module gdsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/gdsh_cell.sv
// One table slot: holds a key and its sum, matches the passing deposit,
// claims it when empty and first in line, and shifts its sum to the head on drain.
module gdsh_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gdsh_pkg::cell_ctl_t      ctl,
	input  gdsh_pkg::tok_t           tok_in,
	output gdsh_pkg::tok_t           tok_out,
	input  logic                     vld_in,
	input  logic [gdsh_pkg::SUM_W-1:0] sum_in,
	output logic                     vld_out,
	output logic [gdsh_pkg::SUM_W-1:0] sum_out
);
	logic                        vld_q;
	logic [gdsh_pkg::KEY_W-1:0]  key_q;
	logic [gdsh_pkg::SUM_W-1:0]  sum_q;
	logic [gdsh_pkg::SUM_W:0]    add;
	logic                        match, claim;

	assign add   = {1'b0, sum_q} + {9'd0, tok_in.energy};
	assign match = tok_in.vld && !tok_in.hit && vld_q && key_q == tok_in.key;
	assign claim = tok_in.vld && !tok_in.hit && !vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.flush) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= vld_in;
		end else if (claim) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sum_q <= sum_in;
		end else if (claim) begin
			key_q <= tok_in.key;
			sum_q <= {8'd0, tok_in.energy};
		end else if (match) begin
			sum_q <= add[gdsh_pkg::SUM_W] ? '1 : add[gdsh_pkg::SUM_W-1:0];
		end
	end

	always_comb begin
		tok_out = tok_in;
		if (match) begin
			tok_out.hit = 1'b1;
			tok_out.sat = add[gdsh_pkg::SUM_W];
		end
		if (claim) begin
			tok_out.hit = 1'b1;
		end
	end

	assign vld_out = vld_q;
	assign sum_out = sum_q;
endmodule

### hw/rtl/gdsh_table.sv
// One keyed table: a row of cells with a registered token between cells.
module gdsh_table #(
	parameter int MAX_CELLS = gdsh_pkg::MAX_CELLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gdsh_pkg::cell_ctl_t        ctl,
	input  gdsh_pkg::tok_t             tok_in,
	output gdsh_pkg::tok_t             tok_out,
	output logic                       head_vld,
	output logic [gdsh_pkg::SUM_W-1:0] head_sum
);
	gdsh_pkg::tok_t                tok_q   [MAX_CELLS+1];
	gdsh_pkg::tok_t                tok_c   [MAX_CELLS];
	logic                          vld_w   [MAX_CELLS+1];
	logic [gdsh_pkg::SUM_W-1:0]    sum_w   [MAX_CELLS+1];

	assign tok_q[0] = tok_in;
	assign vld_w[MAX_CELLS] = 1'b0;
	assign sum_w[MAX_CELLS] = '0;

	for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
		gdsh_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok_q[i]),
			.tok_out (tok_c[i]),
			.vld_in  (vld_w[i+1]),
			.sum_in  (sum_w[i+1]),
			.vld_out (vld_w[i]),
			.sum_out (sum_w[i])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tok_q[i+1] <= '0;
			end else begin
				tok_q[i+1] <= tok_c[i];
			end
		end
	end

	assign tok_out  = tok_q[MAX_CELLS];
	assign head_vld = vld_w[0];
	assign head_sum = sum_w[0];
endmodule

### test/gdsh_checker.sv
`timescale 1ns / 1ps

module gdsh_checker #(
	parameter int MAX_CELLS = gdsh_pkg::MAX_CELLS_DEF,
	parameter int NUM_BINS  = gdsh_pkg::NUM_BINS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  gdsh_pkg::req_t               req,
	input  logic                         done,
	input  gdsh_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [gdsh_pkg::SHIFT_W-1:0] cfg_data,
	output int                           errors,
	output int                           pending
);

	localparam int FIFO_D = 16;

	logic [gdsh_pkg::SHIFT_W-1:0] bin_shift;
	logic [gdsh_pkg::KEY_W-1:0]   cell_keys [gdsh_pkg::TABLES][MAX_CELLS];
	logic [gdsh_pkg::SUM_W-1:0]   cell_sums [gdsh_pkg::TABLES][MAX_CELLS];
	int                           cell_count [gdsh_pkg::TABLES];
	logic [gdsh_pkg::CNT_W-1:0]   bin_counts [gdsh_pkg::TABLES*NUM_BINS];
	logic [gdsh_pkg::CNT_W-1:0]   ovf_counts [gdsh_pkg::TABLES];
	gdsh_pkg::rsp_t               exp_fifo [FIFO_D];
	int                           wr_idx = 0;
	int                           rd_idx = 0;

	assign pending = wr_idx - rd_idx;

	function automatic logic [gdsh_pkg::CNT_W-1:0] bump(logic [gdsh_pkg::CNT_W-1:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

	// Sum one deposit into table t; returns the status code for that table.
	function automatic logic [1:0] add_deposit(int t, logic [gdsh_pkg::KEY_W-1:0] key,
			logic [23:0] e);
		logic [gdsh_pkg::SUM_W:0] s;
		for (int i = 0; i < cell_count[t]; i++) begin
			if (cell_keys[t][i] == key) begin
				s = {1'b0, cell_sums[t][i]} + {9'd0, e};
				if (s[gdsh_pkg::SUM_W]) begin
					cell_sums[t][i] = '1;
					return gdsh_pkg::ST_SAT;
				end
				cell_sums[t][i] = s[gdsh_pkg::SUM_W-1:0];
				return gdsh_pkg::ST_OK;
			end
		end
		if (cell_count[t] >= MAX_CELLS)
			return gdsh_pkg::ST_DROP;
		cell_keys[t][cell_count[t]] = key;
		cell_sums[t][cell_count[t]] = {8'd0, e};
		cell_count[t]++;
		return gdsh_pkg::ST_OK;
	endfunction

	function automatic gdsh_pkg::rsp_t predict_histogram(gdsh_pkg::req_t r);
		gdsh_pkg::rsp_t o;
		logic [1:0]     s0, s1;
		logic [31:0]    b;
		o = '0;
		case (r.mode)
			gdsh_pkg::MODE_DEPOSIT: begin
				s0 = add_deposit(0, r.cell_id, r.energy_ev);
				s1 = gdsh_pkg::ST_OK;
				if (r.volume_type != 2'd0)
					s1 = add_deposit(4 - int'(r.volume_type), r.cell_id, r.energy_ev);
				if (s0 == gdsh_pkg::ST_DROP || s1 == gdsh_pkg::ST_DROP)
					o.status = gdsh_pkg::ST_DROP;
				else if (s0 == gdsh_pkg::ST_SAT || s1 == gdsh_pkg::ST_SAT)
					o.status = gdsh_pkg::ST_SAT;
			end
			gdsh_pkg::MODE_EOE: begin
				for (int t = 0; t < gdsh_pkg::TABLES; t++) begin
					for (int i = 0; i < cell_count[t]; i++) begin
						b = cell_sums[t][i] >> bin_shift;
						if (b >= 32'(NUM_BINS))
							ovf_counts[t] = bump(ovf_counts[t]);
						else
							bin_counts[t*NUM_BINS + int'(b)] =
								bump(bin_counts[t*NUM_BINS + int'(b)]);
						o.value++;
					end
					cell_count[t] = 0;
				end
			end
			gdsh_pkg::MODE_READ: begin
				if (int'(r.bin_index) < NUM_BINS)
					o.value = bin_counts[int'(r.hist_select)*NUM_BINS + int'(r.bin_index)];
				else if (int'(r.bin_index) == NUM_BINS)
					o.value = ovf_counts[r.hist_select];
			end
			gdsh_pkg::MODE_CLEAR: begin
				foreach (bin_counts[i]) bin_counts[i] = '0;
				foreach (ovf_counts[i]) ovf_counts[i] = '0;
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gdsh_pkg::rsp_t want;
		if (!arst_n) begin
			bin_shift = gdsh_pkg::BIN_SHIFT_RST;
			foreach (cell_count[i]) cell_count[i] = 0;
			foreach (bin_counts[i]) bin_counts[i] = '0;
			foreach (ovf_counts[i]) ovf_counts[i] = '0;
			wr_idx = 0;
			rd_idx = 0;
			errors = 0;
		end else begin
			if (done) begin
				if (wr_idx == rd_idx) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status=%0d value=%0d",
							rsp.status, rsp.value);
				end else begin
					want = exp_fifo[rd_idx % FIFO_D];
					rd_idx++;
					if (rsp.status !== want.status) begin
						errors++;
						if (errors <= 10)
							$display("status: expected %0d got %0d", want.status, rsp.status);
					end
					if (rsp.value !== want.value) begin
						errors++;
						if (errors <= 10)
							$display("value: expected %0d got %0d", want.value, rsp.value);
					end
				end
			end
			if (start && !busy) begin
				exp_fifo[wr_idx % FIFO_D] = predict_histogram(req);
				wr_idx++;
			end
			if (cfg_valid && cfg_ready)
				bin_shift = cfg_data;
		end
	end

endmodule

### test/grouped_deposit_sum_histogram_top_tb.sv
`timescale 1ns / 1ps

module grouped_deposit_sum_histogram_top_tb;

	localparam int NB = gdsh_pkg::NUM_BINS_DEF;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	gdsh_pkg::req_t               req = '0;
	logic                         done;
	gdsh_pkg::rsp_t               rsp;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [gdsh_pkg::SHIFT_W-1:0] cfg_data = '0;
	int                           errors;
	int                           pending;

	int                           sent = 0;
	int                           clears_left = 6;
	bit                           no_gaps = 0;
	logic [19:0]                  cell_base;

	always #2 clk = ~clk;

	grouped_deposit_sum_histogram_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	gdsh_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	// Drive one request and hold it until the block takes it, then pause for a random gap, which may be none.
	task automatic send_request(logic [1:0] m, logic [19:0] c, logic [1:0] v,
			logic [23:0] e, logic [1:0] s, logic [13:0] b);
		int gap;
		req <= '{mode: m, cell_id: c, volume_type: v, energy_ev: e,
			hist_select: s, bin_index: b};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
		gap = no_gaps ? 0 : int'($urandom_range(0, 14));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain every outstanding request before touching the block again.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic write_shift(logic [gdsh_pkg::SHIFT_W-1:0] v);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly small bins where counts land, plus overflow and past-overflow reads.
	function automatic logic [13:0] pick_bin();
		case ($urandom_range(0, 5))
			0: return 14'(NB);
			1: return 14'($urandom_range(0, 14'h3FFF));
			default: return 14'($urandom_range(0, 40));
		endcase
	endfunction

	function automatic logic [23:0] pick_energy();
		case ($urandom_range(0, 3))
			0: return 24'($urandom_range(0, 24'hFFFFFF));
			1: return 24'($urandom_range(0, 4095));
			default: return 24'($urandom_range(0, 24'h1FFFFF));
		endcase
	endfunction

	task automatic send_event(int ncells, int ndeps);
		for (int i = 0; i < ndeps && sent < 1450; i++)
			send_request(gdsh_pkg::MODE_DEPOSIT,
				cell_base ^ 20'($urandom_range(0, ncells - 1)),
				2'($urandom_range(0, 3)), pick_energy(), 2'($urandom_range(0, 3)),
				14'($urandom));
		if ($urandom_range(0, 7) != 0)
			send_request(gdsh_pkg::MODE_EOE, 20'($urandom), 2'($urandom),
				24'($urandom), 2'($urandom), 14'($urandom));
		repeat ($urandom_range(1, 5))
			send_request(gdsh_pkg::MODE_READ, 20'($urandom), 2'($urandom),
				24'($urandom), 2'($urandom_range(0, 3)), pick_bin());
	endtask

	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [gdsh_pkg::SHIFT_W-1:0] shifts [4] = '{5'd0, 5'd20, 5'd31, 5'd11};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme ids and energies, every volume, a match, every mode.
		send_request(gdsh_pkg::MODE_DEPOSIT, 20'h00000, 2'd0, 24'h000000, 2'd0, 14'd0);
		send_request(gdsh_pkg::MODE_DEPOSIT, 20'hFFFFF, 2'd3, 24'hFFFFFF, 2'd3, 14'h3FFF);
		send_request(gdsh_pkg::MODE_DEPOSIT, 20'hFFFFF, 2'd2, 24'hFFFFFF, 2'd0, 14'd0);
		send_request(gdsh_pkg::MODE_DEPOSIT, 20'h00000, 2'd1, 24'h000800, 2'd0, 14'd0);
		send_request(gdsh_pkg::MODE_DEPOSIT, 20'h12345, 2'd1, 24'h0007FF, 2'd0, 14'd0);
		send_request(gdsh_pkg::MODE_EOE, 20'h0, 2'd0, 24'h0, 2'd0, 14'd0);
		for (int s = 0; s < 4; s++) begin
			send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'(s), 14'd0);
			send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'(s), 14'd1);
		end
		send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'd0, 14'd8191);
		send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'd1, 14'(NB));
		send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'd2, 14'h3FFF);
		send_request(gdsh_pkg::MODE_CLEAR, 20'h0, 2'd0, 24'h0, 2'd0, 14'd0);
		clears_left--;
		send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'd0, 14'd1);

		// Pause until every result is back, then a large bin width.
		wait_idle();
		write_shift(5'd20);

		// Saturate one cell's sums, then a full table in the same event.
		no_gaps = 1;
		repeat (258)
			send_request(gdsh_pkg::MODE_DEPOSIT, 20'h0ABCD, 2'd3, 24'hFFFFFF, 2'd0, 14'd0);
		no_gaps = 0;
		for (int i = 0; i < 70; i++)
			send_request(gdsh_pkg::MODE_DEPOSIT, 20'(32'h50000 + i),
				2'($urandom_range(1, 3)), pick_energy(), 2'd0, 14'd0);
		send_request(gdsh_pkg::MODE_EOE, 20'h0, 2'd0, 24'h0, 2'd0, 14'd0);
		for (int s = 0; s < 4; s++)
			send_request(gdsh_pkg::MODE_READ, 20'h0, 2'd0, 24'h0, 2'(s), 14'(NB));

		// Random events, reads, occasional clears, noise and bin width changes.
		while (sent < 1450) begin
			cell_base = 20'($urandom_range(0, 20'hFFFFF));
			no_gaps = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 19))
				0: write_shift(($urandom_range(0, 1) != 0)
					? shifts[2'($urandom_range(0, 3))]
					: gdsh_pkg::SHIFT_W'($urandom_range(0, 31)));
				1: if (clears_left > 0) begin
					send_request(gdsh_pkg::MODE_CLEAR, 20'($urandom), 2'($urandom),
						24'($urandom), 2'($urandom), 14'($urandom));
					clears_left--;
				end
				2: send_request(2'($urandom_range(0, 2)), 20'($urandom), 2'($urandom),
					24'($urandom), 2'($urandom), 14'($urandom));
				3: send_event($urandom_range(60, 72), $urandom_range(80, 120));
				default: send_event($urandom_range(1, 8), $urandom_range(1, 12));
			endcase
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
